>>> hdl/wppl_pkg.sv
// Shared constants and types for the pitch / power-limit controller.
`timescale 1ns / 1ps
package wppl_pkg;
    localparam int SPD_W = 14;
    localparam int PWR_W = 20;
    localparam int ANG_W = 17;
    localparam int INT_W = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CUT_IN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_OUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATED_V  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATED_P  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED   = 3'd4;

    localparam logic [ANG_W-1:0] PITCH_FULL = 17'd90000;
    localparam logic [ANG_W-1:0] SLEW_LIMIT = 17'd30000;
    localparam logic signed [INT_W-1:0] INTEG_LIMIT = 18'sd45000;
    localparam logic [PWR_W-1:0] STOP_THRESH = 20'd50;
    localparam logic [1:0] SETTLE_TICKS = 2'd2;
    localparam logic [6:0] HYST_NUM = 7'd97;
    localparam logic [6:0] HYST_DEN = 7'd100;

    // Operand width of the serial multiply / divide unit
    localparam int MD_W = 40;

    typedef struct packed {
        logic              run_status;
        logic [PWR_W-1:0]  avail_pwr;
        logic [ANG_W-1:0]  pitch_setpoint;
        logic [PWR_W-1:0]  estimated_power;
        logic              estimate_valid;
    } t_result;

    typedef struct packed {
        logic [SPD_W-1:0] wind_in;
        logic [PWR_W-1:0] power_setpoint;
        logic [PWR_W-1:0] power_feedback;
        logic             link_up;
    } t_request;

    typedef struct packed {
        logic            start;
        logic            is_div;
        logic [MD_W-1:0] a;
        logic [MD_W-1:0] b;
    } t_md_cmd;
endpackage

>>> hdl/wppl_if.sv
// Valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface wppl_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/wind_pitch_power_limit_controller.sv
// Top level: control sequencer of the pitch / power-limit controller.
// At cut-out the decode state loads the result directly; otherwise a request runs up to six
// serial operations (ramp, feed-forward, estimate: a multiply then a divide) on the unit.
// A request is held in flight until its result is loaded in the output register, plus any wait
// of that register for the sink; a new request is taken once the result is loaded there.
// Reset (synchronous, active low): registers to defaults, stopped, pitch 90 deg.
`timescale 1ns / 1ps
module wind_pitch_power_limit_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wppl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wppl_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    wppl_if.sink                              i_req,
    wppl_if.source                            o_res
);
    import wppl_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_RMUL  = 4'd2;
    localparam logic [3:0] ST_RDIV  = 4'd3;
    localparam logic [3:0] ST_PA    = 4'd4;
    localparam logic [3:0] ST_FMUL  = 4'd5;
    localparam logic [3:0] ST_FDIV  = 4'd6;
    localparam logic [3:0] ST_PITCH = 4'd7;
    localparam logic [3:0] ST_EMUL  = 4'd8;
    localparam logic [3:0] ST_EDIV  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [SPD_W-1:0] r_cut_in, r_cut_out, r_rated_v;
    logic [PWR_W-1:0] r_rated_p;
    logic             r_closed;

    logic                    r_running;
    logic signed [INT_W-1:0] r_integ;
    logic [ANG_W-1:0]        r_prev;
    logic [1:0]              r_settle;

    logic [3:0]       r_st;
    logic             r_wait;
    t_request         r_in;
    logic [PWR_W-1:0] r_pa;
    logic [ANG_W-1:0] r_ff;
    logic [ANG_W-1:0] r_pitch;
    logic             r_ovalid;
    t_result          r_work;
    t_result          r_out;

    t_md_cmd          w_cmd;
    logic             w_done;
    logic [MD_W-1:0]  w_res;

    wppl_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_done (w_done),
        .o_res  (w_res)
    );

    logic w_closed, w_stop_req, w_hyst_low, w_run_nx;
    logic [20:0] w_v100, w_c97;
    assign w_closed   = r_closed;
    assign w_stop_req = w_closed && (r_in.power_setpoint < STOP_THRESH);
    assign w_v100 = 21'(r_in.wind_in) * 21'(HYST_DEN);
    assign w_c97  = 21'(r_cut_in) * 21'(HYST_NUM);
    assign w_hyst_low = w_v100 < w_c97;
    always_comb begin
        if (!r_running) w_run_nx = (r_in.wind_in >= r_cut_in) && !w_stop_req;
        else            w_run_nx = !(w_hyst_low || w_stop_req);
    end

    // integrator / clamp / slew on narrow values
    logic signed [INT_W-1:0] w_integ_a;
    logic signed [INT_W+3:0] w_sum;
    logic signed [INT_W+2:0] w_u;
    logic [ANG_W-1:0]        w_pclamp, w_pitch;
    logic signed [INT_W-1:0] w_integ_b;
    logic [ANG_W:0]          w_hi;
    logic signed [ANG_W+1:0] w_lo;
    logic                    w_noreg;
    logic [1:0]              w_settle;
    assign w_noreg = (!w_closed && r_in.power_setpoint <= STOP_THRESH)
                     || (r_in.power_setpoint >= r_pa);
    always_comb begin
        w_integ_a = w_closed ? r_integ : '0;
        w_settle  = r_settle;
        w_sum     = '0;
        if (w_noreg) begin
            w_integ_a = '0;
            w_settle  = SETTLE_TICKS;
        end else if (r_settle != 2'd0) begin
            w_settle = r_settle - 1'b1;
        end else if (w_closed && r_in.link_up) begin
            w_sum = 22'(w_integ_a) + 22'($signed({1'b0, r_in.power_feedback}))
                    - 22'($signed({1'b0, r_in.power_setpoint}));
            if (w_sum > 22'(INTEG_LIMIT))       w_integ_a = INTEG_LIMIT;
            else if (w_sum < -22'(INTEG_LIMIT)) w_integ_a = -INTEG_LIMIT;
            else                                w_integ_a = w_sum[INT_W-1:0];
        end
        // r_ff is already zero when there is nothing to regulate
        w_u = 21'($signed({1'b0, r_ff})) + 21'(w_integ_a);
        w_integ_b = w_integ_a;
        if (w_u < 0) begin
            w_pclamp  = '0;
            w_integ_b = -INT_W'($signed({1'b0, r_ff}));
        end else if (w_u > 21'($signed({1'b0, PITCH_FULL}))) begin
            w_pclamp  = PITCH_FULL;
            w_integ_b = INT_W'($signed({1'b0, PITCH_FULL}))
                        - INT_W'($signed({1'b0, r_ff}));
        end else begin
            w_pclamp = w_u[ANG_W-1:0];
        end
        w_hi = {1'b0, r_prev} + {1'b0, SLEW_LIMIT};
        w_lo = $signed({2'b0, r_prev}) - $signed({2'b0, SLEW_LIMIT});
        w_pitch = w_pclamp;
        if ({1'b0, w_pclamp} > w_hi) w_pitch = w_hi[ANG_W-1:0];
        if ($signed({2'b0, w_pclamp}) < w_lo) w_pitch = w_lo[ANG_W-1:0];
    end

    logic w_pa_zero_cfg;
    assign w_pa_zero_cfg = (r_cut_out <= r_cut_in) || (r_in.wind_in < r_cut_in);

    always_comb begin
        w_cmd = '0;
        case (r_st)
            ST_RMUL: begin
                w_cmd.start = !r_wait;
                w_cmd.a = MD_W'(r_rated_p);
                w_cmd.b = MD_W'(r_in.wind_in - r_cut_in);
            end
            ST_RDIV: begin
                w_cmd.start = !r_wait; w_cmd.is_div = 1'b1;
                w_cmd.a = w_res;
                w_cmd.b = MD_W'(r_rated_v - r_cut_in);
            end
            ST_FMUL: begin
                w_cmd.start = !r_wait;
                w_cmd.a = MD_W'(PITCH_FULL);
                w_cmd.b = MD_W'(r_pa - r_in.power_setpoint);
            end
            ST_FDIV: begin
                w_cmd.start = !r_wait; w_cmd.is_div = 1'b1;
                w_cmd.a = w_res;
                w_cmd.b = MD_W'(r_pa);
            end
            ST_EMUL: begin
                w_cmd.start = !r_wait;
                w_cmd.a = MD_W'(r_pa);
                w_cmd.b = MD_W'(PITCH_FULL - r_pitch);
            end
            ST_EDIV: begin
                w_cmd.start = !r_wait; w_cmd.is_div = 1'b1;
                w_cmd.a = w_res;
                w_cmd.b = MD_W'(PITCH_FULL);
            end
            default: w_cmd = '0;
        endcase
        // operand of a division comes from the finished multiply
        if ((r_st == ST_RDIV || r_st == ST_FDIV || r_st == ST_EDIV) && r_wait)
            w_cmd.start = 1'b0;
    end

    logic w_load_out;
    assign w_load_out = (r_st == ST_OUT) && (!r_ovalid || o_res.ready);

    assign i_req.ready = (r_st == ST_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_in  <= 14'd300;
            r_cut_out <= 14'd2500;
            r_rated_v <= 14'd1200;
            r_rated_p <= 20'd10000;
            r_closed  <= 1'b1;
            r_running <= 1'b0;
            r_integ   <= '0;
            r_prev    <= PITCH_FULL;
            r_settle  <= SETTLE_TICKS;
            r_st      <= ST_IDLE;
            r_wait    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CUT_IN:  r_cut_in  <= i_cfg_data[SPD_W-1:0];
                    REG_CUT_OUT: r_cut_out <= i_cfg_data[SPD_W-1:0];
                    REG_RATED_V: r_rated_v <= i_cfg_data[SPD_W-1:0];
                    REG_RATED_P: r_rated_p <= i_cfg_data;
                    REG_CLOSED:  r_closed  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_in <= i_req.data;
                        r_st <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_wait <= 1'b0;
                    if (r_in.wind_in >= r_cut_out) begin
                        r_running <= 1'b0;
                        r_integ   <= '0;
                        r_prev    <= PITCH_FULL;
                        r_work    <= '{1'b0, '0, PITCH_FULL, '0, !r_closed};
                        r_st      <= ST_OUT;
                    end else begin
                        r_running <= w_run_nx;
                        if (w_pa_zero_cfg) begin
                            r_pa <= '0; r_st <= ST_PA;
                        end else if (r_in.wind_in >= r_rated_v || r_rated_v <= r_cut_in) begin
                            r_pa <= r_rated_p; r_st <= ST_PA;
                        end else begin
                            r_st <= ST_RMUL;
                        end
                    end
                end
                ST_RMUL, ST_FMUL, ST_EMUL: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_wait <= 1'b0;
                        r_st   <= r_st + 1'b1;
                    end
                end
                ST_RDIV, ST_FDIV, ST_EDIV: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_wait <= 1'b0;
                        if (r_st == ST_RDIV) begin
                            r_pa <= w_res[PWR_W-1:0]; r_st <= ST_PA;
                        end else if (r_st == ST_FDIV) begin
                            r_ff <= w_res[ANG_W-1:0]; r_st <= ST_PITCH;
                        end else begin
                            r_work.estimated_power <= (w_res > MD_W'(r_rated_p))
                                ? r_rated_p : w_res[PWR_W-1:0];
                            r_st <= ST_OUT;
                        end
                    end
                end
                ST_PA: begin
                    if (!r_running || r_pa == '0) begin
                        r_integ  <= '0;
                        r_prev   <= PITCH_FULL;
                        r_settle <= SETTLE_TICKS;
                        r_work   <= '{r_running, r_pa, PITCH_FULL, '0, !r_closed};
                        r_st     <= ST_OUT;
                    end else if (w_noreg) begin
                        r_ff <= '0;
                        r_st <= ST_PITCH;
                    end else begin
                        r_st <= ST_FMUL;
                    end
                end
                ST_PITCH: begin
                    r_integ  <= w_integ_b;
                    r_settle <= w_settle;
                    r_prev   <= w_pitch;
                    r_pitch  <= w_pitch;
                    r_work   <= '{r_running, r_pa, w_pitch, '0, !r_closed};
                    r_st     <= r_closed ? ST_OUT : ST_EMUL;
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_out <= r_work;
                        r_st  <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/wppl_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module wppl_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wppl_pkg::t_md_cmd  i_cmd,
    output logic               o_done,
    output logic [wppl_pkg::MD_W-1:0] o_res
);
    import wppl_pkg::*;

    localparam int CNT_W = $clog2(MD_W + 1);

    logic              r_busy, n_busy;
    logic              r_div, n_div;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MD_W-1:0]   r_a, n_a;
    logic [MD_W-1:0]   r_b, n_b;
    logic [MD_W-1:0]   r_acc, n_acc;
    logic              r_done, n_done;
    logic [MD_W:0]     w_rem;
    logic [MD_W:0]     w_sub;

    assign w_rem = {r_acc, r_a[MD_W-1]};
    assign w_sub = w_rem - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_div  = i_cmd.is_div;
            n_cnt  = CNT_W'(MD_W);
            n_a    = i_cmd.a;
            n_b    = i_cmd.b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_div) begin
                // quotient bits shift into r_a, remainder in r_acc
                if (!w_sub[MD_W]) begin
                    n_acc = w_sub[MD_W-1:0];
                    n_a   = {r_a[MD_W-2:0], 1'b1};
                end else begin
                    n_acc = w_rem[MD_W-1:0];
                    n_a   = {r_a[MD_W-2:0], 1'b0};
                end
            end else begin
                n_acc = {r_acc[MD_W-2:0], 1'b0} + (r_a[MD_W-1] ? r_b : '0);
                n_a   = {r_a[MD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_res  = r_div ? r_a : r_acc;
endmodule
